@@ sv/lome_pkg.sv @@
// Package for the limit order matching engine: constants, codes, types.
`default_nettype none
package lome_pkg;

    localparam int BOOK_DEPTH  = 32;
    localparam int NUM_SYMBOLS = 16;
    localparam int ID_BITS     = 16;

    localparam int SLOT_BITS = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(BOOK_DEPTH + 1);
    localparam int SYM_BITS  = $clog2(NUM_SYMBOLS);
    localparam int ADDR_BITS = SYM_BITS + 1 + SLOT_BITS;
    localparam int SIDES     = 2 ** (SYM_BITS + 1);

    localparam logic [1:0] OP_LIMIT  = 2'd0;
    localparam logic [1:0] OP_MARKET = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_PARTIAL   = 3'd1;
    localparam logic [2:0] ST_FILLED    = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic [2:0] WHY_NONE      = 3'd0;
    localparam logic [2:0] WHY_ZERO_QTY  = 3'd1;
    localparam logic [2:0] WHY_NO_SYMBOL = 3'd2;
    localparam logic [2:0] WHY_BAD_LIMIT = 3'd3;
    localparam logic [2:0] WHY_NEG_PRICE = 3'd4;
    localparam logic [2:0] WHY_DUP_ID    = 3'd5;
    localparam logic [2:0] WHY_MISSING   = 3'd6;
    localparam logic [2:0] WHY_FULL      = 3'd7;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic signed [31:0] price;
        logic [31:0]        qty;
        logic [15:0]        id;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VAL, S_MRD, S_MCHK, S_MEMIT, S_SHRD, S_SHWR,
        S_RSRD, S_RSCHK, S_UPRD, S_UPWR, S_INS, S_CRD, S_CCHK, S_STATUS
    } t_state;

endpackage
`default_nettype wire

@@ sv/lome_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module lome_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/limit_order_matching_engine.sv @@
// Top level of the limit order matching engine: sequencer around book and id memories.
//
// Channel  | Direction | Handshake                   | Word
// orders   | in        | i_in_valid / o_in_ready     | one order
// results  | out       | o_out_valid / i_out_ready   | one trade or status record
//
// An unknown operation goes straight to its status word, a rejected order after validation.
// An accepted order trades against the head of the opposite side until it is filled or a
// priced-out head stops it; each emptied resting entry is removed by shifting its side up,
// and a limit remainder rests by a search for its slot and a shift down. A cancel searches
// the named book, then every book, entry by entry, and removes the match by the same shift.
// Reset first clears the 2**ID_BITS (65536) id entries; a stalled result holds the sequencer.
`default_nettype none
module limit_order_matching_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_operation,
    input  wire logic               i_side,
    input  wire logic [15:0]        i_order_id,
    input  wire logic [3:0]         i_symbol,
    input  wire logic signed [31:0] i_price,
    input  wire logic [31:0]        i_quantity,
    input  wire logic [47:0]        i_timestamp,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_kind,
    output logic                    o_last,
    output logic [63:0]             o_trade_number,
    output logic [15:0]             o_buyer_id,
    output logic [15:0]             o_seller_id,
    output logic [3:0]              o_trade_symbol,
    output logic signed [31:0]      o_fill_price,
    output logic [31:0]             o_exec_quantity,
    output logic [47:0]             o_trade_time,
    output logic [2:0]              o_status,
    output logic [2:0]              o_reject_reason,
    output logic [31:0]             o_filled_total
);
    localparam int SB = lome_pkg::SYM_BITS;
    localparam int CB = lome_pkg::CNT_BITS;
    localparam int LB = lome_pkg::SLOT_BITS;
    localparam int AB = lome_pkg::ADDR_BITS;
    localparam int IB = lome_pkg::ID_BITS;

    lome_pkg::t_state r_state, n_state;

    logic [1:0]         r_op;
    logic               r_side;
    logic [15:0]        r_id;
    logic [3:0]         r_sym;
    logic signed [31:0] r_px;
    logic [31:0]        r_rem, r_filled, r_q;
    logic [47:0]        r_tm;
    logic [63:0]        r_next_trade;
    logic [2:0]         r_st, r_why;
    logic [SB-1:0]      r_bsym;
    logic               r_bside, r_named;
    logic [CB-1:0]      r_i, r_n, r_pos;
    logic [IB-1:0]      r_clr;
    lome_pkg::t_entry   r_rest;
    logic [CB-1:0]      r_cnt [lome_pkg::SIDES];
    logic               r_ov;

    // Book and id memories.
    logic                   book_we;
    logic [AB-1:0]          book_waddr, book_raddr;
    lome_pkg::t_entry       book_wdata, book_rd;
    logic [lome_pkg::ENTRY_BITS-1:0] book_rdata;
    logic                   seen_we, seen_wdata, seen_rdata;
    logic [IB-1:0]          seen_waddr, seen_raddr;

    lome_ram #(.WIDTH(lome_pkg::ENTRY_BITS), .DEPTH(2 ** AB)) u_book (
        .i_clk(i_clk), .i_we(book_we), .i_waddr(book_waddr), .i_wdata(book_wdata),
        .i_raddr(book_raddr), .o_rdata(book_rdata)
    );

    lome_ram #(.WIDTH(1), .DEPTH(2 ** IB)) u_seen (
        .i_clk(i_clk), .i_we(seen_we), .i_waddr(seen_waddr), .i_wdata(seen_wdata),
        .i_raddr(seen_raddr), .o_rdata(seen_rdata)
    );

    assign book_rd = book_rdata;

    // Shared decisions.
    logic [CB-1:0] cur_cnt, own_cnt;
    logic          out_free, out_load, worse, sym_ok, in_sym_ok, rest_go, full, last_sym;
    logic [31:0]   q_min;
    logic [2:0]    why_val, fin_st;

    assign cur_cnt  = r_cnt[{r_bsym, r_bside}];
    assign own_cnt  = r_cnt[{r_bsym, r_side}];
    assign out_free = !r_ov || i_out_ready;
    assign out_load = out_free &&
                      (r_state == lome_pkg::S_MEMIT || r_state == lome_pkg::S_STATUS);
    assign worse    = (r_op == lome_pkg::OP_LIMIT) &&
                      (r_side ? (book_rd.price < r_px) : (book_rd.price > r_px));
    assign sym_ok    = (r_sym != 4'd0) && ({28'd0, r_sym} < 32'(lome_pkg::NUM_SYMBOLS));
    assign in_sym_ok = (i_symbol != 4'd0) &&
                       ({28'd0, i_symbol} < 32'(lome_pkg::NUM_SYMBOLS));
    assign rest_go  = (r_op == lome_pkg::OP_LIMIT) && (r_rem != 32'd0);
    assign full     = {{(32-CB){1'b0}}, own_cnt} >= 32'(lome_pkg::BOOK_DEPTH);
    assign q_min    = (r_rem < book_rd.qty) ? r_rem : book_rd.qty;
    assign last_sym = r_bsym == SB'(lome_pkg::NUM_SYMBOLS - 1);
    assign fin_st   = (r_rem == 32'd0) ? lome_pkg::ST_FILLED :
                      ((r_filled != 32'd0) ? lome_pkg::ST_PARTIAL : lome_pkg::ST_ACCEPTED);

    always_comb begin
        priority if (r_rem == 32'd0) why_val = lome_pkg::WHY_ZERO_QTY;
        else if (!sym_ok) why_val = lome_pkg::WHY_NO_SYMBOL;
        else if (r_op == lome_pkg::OP_LIMIT && r_px <= 32'sd0) why_val = lome_pkg::WHY_BAD_LIMIT;
        else if (r_px < 32'sd0) why_val = lome_pkg::WHY_NEG_PRICE;
        else if (seen_rdata) why_val = lome_pkg::WHY_DUP_ID;
        else why_val = lome_pkg::WHY_NONE;
    end

    assign o_in_ready  = (r_state == lome_pkg::S_IDLE);
    assign o_out_valid = r_ov;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lome_pkg::S_CLEAR: if (r_clr == {IB{1'b1}}) n_state = lome_pkg::S_IDLE;
            lome_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_operation)
                        lome_pkg::OP_NONE:   n_state = lome_pkg::S_STATUS;
                        lome_pkg::OP_CANCEL: n_state = lome_pkg::S_CRD;
                        default:             n_state = lome_pkg::S_VAL;
                    endcase
                end
            end
            lome_pkg::S_VAL:
                n_state = (why_val != lome_pkg::WHY_NONE) ? lome_pkg::S_STATUS : lome_pkg::S_MRD;
            lome_pkg::S_MRD: begin
                if (r_rem == 32'd0 || cur_cnt == '0) begin
                    n_state = (rest_go && !full) ? lome_pkg::S_RSRD : lome_pkg::S_STATUS;
                end else begin
                    n_state = lome_pkg::S_MCHK;
                end
            end
            lome_pkg::S_MCHK: begin
                if (worse) begin
                    n_state = (rest_go && !full) ? lome_pkg::S_RSRD : lome_pkg::S_STATUS;
                end else begin
                    n_state = lome_pkg::S_MEMIT;
                end
            end
            lome_pkg::S_MEMIT: if (out_free) begin
                n_state = (r_rest.qty == r_q) ? lome_pkg::S_SHRD : lome_pkg::S_MRD;
            end
            lome_pkg::S_SHRD: begin
                if (r_i + 1'b1 < r_n) n_state = lome_pkg::S_SHWR;
                else n_state = (r_op == lome_pkg::OP_CANCEL) ? lome_pkg::S_STATUS : lome_pkg::S_MRD;
            end
            lome_pkg::S_SHWR: n_state = lome_pkg::S_SHRD;
            lome_pkg::S_RSRD:
                n_state = (r_i < cur_cnt) ? lome_pkg::S_RSCHK : lome_pkg::S_UPRD;
            lome_pkg::S_RSCHK: begin
                if (r_side ? (r_px < book_rd.price) : (r_px > book_rd.price)) begin
                    n_state = lome_pkg::S_UPRD;
                end else begin
                    n_state = lome_pkg::S_RSRD;
                end
            end
            lome_pkg::S_UPRD: n_state = (r_i > r_pos) ? lome_pkg::S_UPWR : lome_pkg::S_INS;
            lome_pkg::S_UPWR: n_state = lome_pkg::S_UPRD;
            lome_pkg::S_INS:  n_state = lome_pkg::S_STATUS;
            lome_pkg::S_CRD: begin
                if (r_i >= cur_cnt && r_bside && !r_named && last_sym) begin
                    n_state = lome_pkg::S_STATUS;
                end else if (r_i < cur_cnt) begin
                    n_state = lome_pkg::S_CCHK;
                end
            end
            lome_pkg::S_CCHK:
                n_state = (book_rd.id == r_id) ? lome_pkg::S_SHRD : lome_pkg::S_CRD;
            lome_pkg::S_STATUS: if (out_free) n_state = lome_pkg::S_IDLE;
            default: n_state = lome_pkg::S_IDLE;
        endcase
    end

    // Memory control.
    always_comb begin
        book_we    = 1'b0;
        book_waddr = {r_bsym, r_bside, r_i[LB-1:0]};
        book_wdata = book_rd;
        book_raddr = {r_bsym, r_bside, r_i[LB-1:0]};
        seen_we    = 1'b0;
        seen_waddr = IB'(r_id);
        seen_wdata = 1'b1;
        seen_raddr = IB'(i_order_id);
        unique case (r_state)
            lome_pkg::S_CLEAR: begin
                seen_we    = 1'b1;
                seen_waddr = r_clr;
                seen_wdata = 1'b0;
            end
            lome_pkg::S_VAL: seen_we = (why_val == lome_pkg::WHY_NONE);
            lome_pkg::S_MRD: book_raddr = {r_bsym, r_bside, {LB{1'b0}}};
            lome_pkg::S_MEMIT: begin
                // A partial fill leaves the head entry in place with less quantity.
                book_we    = out_free && (r_rest.qty != r_q);
                book_waddr = {r_bsym, r_bside, {LB{1'b0}}};
                book_wdata = '{price: r_rest.price, qty: r_rest.qty - r_q, id: r_rest.id};
            end
            lome_pkg::S_SHRD: book_raddr = {r_bsym, r_bside, LB'(r_i + 1'b1)};
            lome_pkg::S_SHWR: book_we = 1'b1;
            lome_pkg::S_UPRD: book_raddr = {r_bsym, r_bside, LB'(r_i - 1'b1)};
            lome_pkg::S_UPWR: book_we = 1'b1;
            lome_pkg::S_INS: begin
                book_we    = 1'b1;
                book_waddr = {r_bsym, r_bside, r_pos[LB-1:0]};
                book_wdata = '{price: r_px, qty: r_rem, id: r_id};
            end
            default: ;
        endcase
    end

    // Datapath and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lome_pkg::S_CLEAR;
            r_clr        <= '0;
            r_ov         <= 1'b0;
            r_next_trade <= 64'd1;
            for (int k = 0; k < lome_pkg::SIDES; k++) r_cnt[k] <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
            unique case (r_state)
                lome_pkg::S_CLEAR: r_clr <= r_clr + 1'b1;
                lome_pkg::S_IDLE: if (i_in_valid) begin
                    r_op     <= i_operation;
                    r_side   <= i_side;
                    r_id     <= i_order_id;
                    r_sym    <= i_symbol;
                    r_px     <= i_price;
                    r_rem    <= i_quantity;
                    r_tm     <= i_timestamp;
                    r_filled <= 32'd0;
                    r_st     <= lome_pkg::ST_REJECTED;
                    r_why    <= lome_pkg::WHY_NONE;
                    r_named  <= in_sym_ok;
                    r_bsym   <= in_sym_ok ? SB'(i_symbol) : '0;
                    r_bside  <= 1'b0;
                    r_i      <= '0;
                end
                lome_pkg::S_VAL: begin
                    r_why   <= why_val;
                    r_bsym  <= SB'(r_sym);
                    r_bside <= ~r_side;
                end
                lome_pkg::S_MRD: begin
                    if (r_rem == 32'd0 || cur_cnt == '0) begin
                        r_st    <= fin_st;
                        r_why   <= (rest_go && full) ? lome_pkg::WHY_FULL : lome_pkg::WHY_NONE;
                        r_bside <= r_side;
                        r_i     <= '0;
                    end
                end
                lome_pkg::S_MCHK: begin
                    r_rest <= book_rd;
                    r_q    <= q_min;
                    if (worse) begin
                        r_st    <= fin_st;
                        r_why   <= (rest_go && full) ? lome_pkg::WHY_FULL : lome_pkg::WHY_NONE;
                        r_bside <= r_side;
                        r_i     <= '0;
                    end
                end
                lome_pkg::S_MEMIT: if (out_free) begin
                    o_kind          <= lome_pkg::KIND_TRADE;
                    o_last          <= 1'b0;
                    o_trade_number  <= r_next_trade;
                    o_buyer_id      <= r_side ? r_rest.id : r_id;
                    o_seller_id     <= r_side ? r_id : r_rest.id;
                    o_trade_symbol  <= r_sym;
                    o_fill_price    <= r_rest.price;
                    o_exec_quantity <= r_q;
                    o_trade_time    <= r_tm;
                    o_status        <= lome_pkg::ST_ACCEPTED;
                    o_reject_reason <= lome_pkg::WHY_NONE;
                    o_filled_total  <= 32'd0;
                    r_next_trade    <= r_next_trade + 64'd1;
                    r_rem           <= r_rem - r_q;
                    r_filled        <= r_filled + r_q;
                    if (r_rest.qty == r_q) begin
                        r_i <= '0;
                        r_n <= cur_cnt;
                        r_cnt[{r_bsym, r_bside}] <= cur_cnt - 1'b1;
                    end
                end
                lome_pkg::S_SHRD: begin
                    if (!(r_i + 1'b1 < r_n) && r_op == lome_pkg::OP_CANCEL) begin
                        r_st  <= lome_pkg::ST_CANCELLED;
                        r_why <= lome_pkg::WHY_NONE;
                    end
                end
                lome_pkg::S_SHWR: r_i <= r_i + 1'b1;
                lome_pkg::S_RSRD: begin
                    if (!(r_i < cur_cnt)) begin
                        r_pos <= cur_cnt;
                        r_i   <= cur_cnt;
                    end
                end
                lome_pkg::S_RSCHK: begin
                    if (r_side ? (r_px < book_rd.price) : (r_px > book_rd.price)) begin
                        r_pos <= r_i;
                        r_i   <= cur_cnt;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                lome_pkg::S_UPWR: r_i <= r_i - 1'b1;
                lome_pkg::S_INS: r_cnt[{r_bsym, r_bside}] <= cur_cnt + 1'b1;
                lome_pkg::S_CRD: begin
                    if (r_i >= cur_cnt) begin
                        r_i <= '0;
                        if (!r_bside) begin
                            r_bside <= 1'b1;
                        end else if (r_named) begin
                            // The named book came up empty; now sweep every book.
                            r_named <= 1'b0;
                            r_bsym  <= '0;
                            r_bside <= 1'b0;
                        end else if (last_sym) begin
                            r_st  <= lome_pkg::ST_REJECTED;
                            r_why <= lome_pkg::WHY_MISSING;
                        end else begin
                            r_bsym  <= r_bsym + 1'b1;
                            r_bside <= 1'b0;
                        end
                    end
                end
                lome_pkg::S_CCHK: begin
                    if (book_rd.id == r_id) begin
                        r_n <= cur_cnt;
                        r_cnt[{r_bsym, r_bside}] <= cur_cnt - 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                lome_pkg::S_STATUS: if (out_free) begin
                    o_kind          <= lome_pkg::KIND_STATUS;
                    o_last          <= 1'b1;
                    o_trade_number  <= 64'd0;
                    o_buyer_id      <= 16'd0;
                    o_seller_id     <= 16'd0;
                    o_trade_symbol  <= 4'd0;
                    o_fill_price    <= 32'sd0;
                    o_exec_quantity <= 32'd0;
                    o_trade_time    <= 48'd0;
                    o_status        <= r_st;
                    o_reject_reason <= r_why;
                    o_filled_total  <= (r_op == lome_pkg::OP_CANCEL || r_op == lome_pkg::OP_NONE)
                                       ? 32'd0 : r_filled;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/lome_checker.sv @@
// Port-level checker for the matching engine, bound to the top level.
`default_nettype none
module lome_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_kind,
    input wire logic        o_last,
    input wire logic [31:0] o_exec_quantity,
    input wire logic [2:0]  o_status
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_status))
        else $error("stalled result word changed");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == o_last))
        else $error("last flag does not match a status word");

    a_trade_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> o_exec_quantity != 32'd0)
        else $error("trade word with zero quantity");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_status <= 3'd4)
        else $error("status code out of range");
endmodule

bind limit_order_matching_engine lome_checker u_lome_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_kind(o_kind), .o_last(o_last),
    .o_exec_quantity(o_exec_quantity), .o_status(o_status)
);
`default_nettype wire
